>>> design/ttw_pkg.sv
// text terminal writer: shared types, sizes, codes and the cell format
// no dependencies
package ttw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int CELL_AW   = $clog2(CELLS);
	localparam int CUR_W     = $clog2(CELLS + 1);
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int CELL_W    = 16;
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int POS_W     = 11;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 4;

	localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
	localparam logic [COLOR_W-1:0]   RESET_FG     = 4'hF;
	localparam logic [COLOR_W-1:0]   RESET_BG     = 4'h0;
	localparam logic [CELL_W-1:0]    RESET_CELL   = {RESET_BG, RESET_FG, 8'h00};

	localparam logic [CFG_IDX_W-1:0] REG_FG = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 4'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT  = 2'd0,
		CMD_FILL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_PUT,
		ST_FILL,
		ST_READ,
		ST_RDATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [CELL_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} res_t;

	function automatic logic [CELL_W-1:0] make_cell(
		input logic [COLOR_W-1:0] bg,
		input logic [COLOR_W-1:0] fg,
		input logic [CHAR_W-1:0]  ch
	);
		return {bg, fg, ch};
	endfunction

endpackage

>>> design/text_terminal_writer_top.sv
// text terminal writer: top level with colour registers and output register
// depends on ttw_pkg, ttw_ctrl and ttw_screen_ram
//
// Input channel (in_valid/in_ready) takes one command word: cmd, char_code, cell_index.
// Output channel (out_valid/out_ready) returns one word per command: read_data and
// cursor_pos. Colour registers are written through cfg_valid/cfg_ready with cfg_index
// (0 foreground, 1 background) and cfg_data; cfg_ready is always high.
// One command is in work at a time; in_ready is high only while the sequencer is idle.
// Put: a put with the cursor past the end first scrolls, one cell copied or blanked
// per cycle on the single memory write port. Fill: one cell per cycle.
// Read: registered memory read, skipped for an index outside the screen.
// Unused command: returns a result word with no memory access.
// The result sits in an output register, so a stalled receiver holds one finished
// word while the next command is taken and worked; the sequencer then waits.
// After reset the screen memory is cleared, one cell per cycle, with in_ready low;
// the cursor is homed and the colours return to their defaults.
module text_terminal_writer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ttw_pkg::CMD_W-1:0]     cmd,
	input  logic [ttw_pkg::CHAR_W-1:0]    char_code,
	input  logic [ttw_pkg::IDX_W-1:0]     cell_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ttw_pkg::CELL_W-1:0]    read_data,
	output logic [ttw_pkg::POS_W-1:0]     cursor_pos,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ttw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttw_pkg::COLOR_W-1:0]   cfg_data
);
	import ttw_pkg::*;

	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               out_valid_q;
	logic [CELL_W-1:0]  read_data_q;
	logic [POS_W-1:0]   cursor_pos_q;
	res_t               res;
	logic               res_ready;
	logic               mem_we;
	logic [CELL_AW-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0]  mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q        <= RESET_FG;
			bg_q        <= RESET_BG;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_FG) begin
				fg_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_BG) begin
				bg_q <= cfg_data;
			end
			if (res_ready) begin
				out_valid_q <= res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			read_data_q  <= res.data;
			cursor_pos_q <= res.pos;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign cursor_pos = cursor_pos_q;

	ttw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_code  (char_code),
		.cell_index (cell_index),
		.fg         (fg_q),
		.bg         (bg_q),
		.res        (res),
		.res_ready  (res_ready),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ttw_screen_ram #(
		.DEPTH (CELLS),
		.WIDTH (CELL_W),
		.AW    (CELL_AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> design/ttw_screen_ram.sv
// text terminal writer: screen memory, one write port, one registered read port
// no dependencies
module ttw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/ttw_ctrl.sv
// text terminal writer: command sequencer with the shared cell address counter
// depends on ttw_pkg
module ttw_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ttw_pkg::CMD_W-1:0]     cmd,
	input  logic [ttw_pkg::CHAR_W-1:0]    char_code,
	input  logic [ttw_pkg::IDX_W-1:0]     cell_index,
	input  logic [ttw_pkg::COLOR_W-1:0]   fg,
	input  logic [ttw_pkg::COLOR_W-1:0]   bg,
	output ttw_pkg::res_t                 res,
	input  logic                          res_ready,
	output logic                          mem_we,
	output logic [ttw_pkg::CELL_AW-1:0]   mem_waddr,
	output logic [ttw_pkg::CELL_W-1:0]    mem_wdata,
	output logic [ttw_pkg::CELL_AW-1:0]   mem_raddr,
	input  logic [ttw_pkg::CELL_W-1:0]    mem_rdata
);
	import ttw_pkg::*;

	state_t              state_q, state_d;
	logic [CELL_AW-1:0]  cnt_q, cnt_d;
	logic [CUR_W-1:0]    cursor_q, cursor_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [CELL_W-1:0]   data_q, data_d;
	logic [CHAR_W-1:0]   char_q;
	logic [CELL_AW-1:0]  ridx_q;
	logic                load;
	logic                cpy_s1, cpy_d;
	logic [CELL_AW-1:0]  cpy_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			cursor_q <= '0;
			col_q    <= '0;
			cpy_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			cursor_q <= cursor_d;
			col_q    <= col_d;
			cpy_s1   <= cpy_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q      <= data_d;
		cpy_addr_s1 <= cnt_q;
		if (load) begin
			char_q <= char_code;
			ridx_q <= CELL_AW'(cell_index);
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cursor_d  = cursor_q;
		col_d     = col_q;
		data_d    = data_q;
		cpy_d     = 1'b0;
		load      = 1'b0;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = make_cell(bg, fg, char_q);
		mem_raddr = cnt_q + CELL_AW'(COLUMNS);
		res.valid = 1'b0;
		res.data  = data_q;
		res.pos   = POS_W'(cursor_q);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = RESET_CELL;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == CELL_AW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load   = 1'b1;
					data_d = '0;
					cnt_d  = '0;
					unique case (cmd_t'(cmd))
						CMD_PUT: begin
							state_d = (cursor_q == CUR_W'(CELLS)) ? ST_SCROLL : ST_PUT;
						end
						CMD_FILL: state_d = ST_FILL;
						CMD_READ: begin
							state_d = (int'(cell_index) < CELLS) ? ST_READ : ST_DONE;
						end
						CMD_NONE: state_d = ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_SCROLL: begin
				// copy pipeline: read row below, write in the next cycle
				if (cpy_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cpy_addr_s1;
					mem_wdata = mem_rdata;
				end
				if (cnt_q == CELL_AW'(CELLS - COLUMNS)) begin
					state_d = ST_BLANK;
				end else begin
					cpy_d = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_wdata = make_cell(bg, fg, '0);
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == CELL_AW'(CELLS - 1)) begin
					cnt_d    = '0;
					cursor_d = cursor_q - CUR_W'(COLUMNS);
					col_d    = '0;
					state_d  = ST_PUT;
				end
			end
			ST_PUT: begin
				if (char_q == NEWLINE_CODE) begin
					cursor_d = cursor_q + CUR_W'(COLUMNS) - CUR_W'(col_q);
					col_d    = '0;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = CELL_AW'(cursor_q);
					cursor_d  = cursor_q + 1'b1;
					col_d     = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CELL_AW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				mem_raddr = ridx_q;
				state_d   = ST_RDATA;
			end
			ST_RDATA: begin
				data_d  = mem_rdata;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(CELLS))
		else $error("cursor beyond end of screen");
	a_col_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q == CUR_W'(CELLS)) |-> (col_q == '0))
		else $error("column not zero with cursor past end");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready straight after accepting a word");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE && state_q != ST_DONE))
		else $error("memory write while idle or holding a result");
`endif

endmodule

>>> test/tb_text_terminal_writer_top.sv
// testbench for text_terminal_writer_top: directed script then random put, fill, read and unused words
// keeps a shadow screen, cursor and colour pair, checks every result word in order
// depends on ttw_pkg and the design under design/
module tb_text_terminal_writer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ttw_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 16;
	localparam int PHASES         = 8;
	localparam int WORDS_PER_PHASE = 100;
	localparam int NROWS          = 27;

	// no register behind this index
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		cmd_t                   op;
		logic [CHAR_W-1:0]      ch;
		logic [IDX_W-1:0]       ix;
		logic [5:0]             reps;
		logic                   typed;
		logic [CELL_W-1:0]      t_data;
		logic [POS_W-1:0]       t_pos;
		logic [CFG_IDX_W-1:0]   reg_sel;
		logic [COLOR_W-1:0]     reg_val;
	} script_row_t;

	typedef struct packed {
		logic [CELL_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} cell_word_t;

	localparam script_row_t SCRIPT [NROWS] = '{
		'{ROW_WORD, CMD_READ, 8'h00, 11'd0,    6'd1,  1'b1, 16'h0F00, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1999, 6'd1,  1'b1, 16'h0F00, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd2000, 6'd1,  1'b1, 16'h0000, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'hFF, 11'd2047, 6'd1,  1'b1, 16'h0000, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_NONE, 8'hFF, 11'd2047, 6'd1,  1'b1, 16'h0000, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h41, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd1,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd0,    6'd1,  1'b1, 16'h0F41, 11'd1,    REG_FG, 4'h0},
		'{ROW_REG,  CMD_NONE, 8'h00, 11'd0,    6'd0,  1'b0, 16'h0000, 11'd0,    REG_FG, 4'h0},
		'{ROW_REG,  CMD_NONE, 8'h00, 11'd0,    6'd0,  1'b0, 16'h0000, 11'd0,    REG_BG, 4'hF},
		'{ROW_REG,  CMD_NONE, 8'h00, 11'd0,    6'd0,  1'b0, 16'h0000, 11'd0,    REG_SPARE, 4'h5},
		'{ROW_WORD, CMD_PUT,  8'hFF, 11'd2047, 6'd1,  1'b1, 16'h0000, 11'd2,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1,    6'd1,  1'b1, 16'hF0FF, 11'd2,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h00, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd3,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h0A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd80,   REG_FG, 4'h0},
		'{ROW_WORD, CMD_FILL, 8'h0A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd80,   REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd0,    6'd1,  1'b1, 16'hF00A, 11'd80,   REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h0A, 11'd0,    6'd23, 1'b0, 16'h0000, 11'd0,    REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h0A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd2000, REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1999, 6'd1,  1'b1, 16'hF00A, 11'd2000, REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h5A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd1921, REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1920, 6'd1,  1'b1, 16'hF05A, 11'd1921, REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1999, 6'd1,  1'b1, 16'hF000, 11'd1921, REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd0,    6'd1,  1'b1, 16'hF00A, 11'd1921, REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h0A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd2000, REG_FG, 4'h0},
		'{ROW_WORD, CMD_PUT,  8'h0A, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd2000, REG_FG, 4'h0},
		'{ROW_WORD, CMD_FILL, 8'h80, 11'd0,    6'd1,  1'b1, 16'h0000, 11'd2000, REG_FG, 4'h0},
		'{ROW_WORD, CMD_READ, 8'h00, 11'd1999, 6'd1,  1'b1, 16'hF080, 11'd2000, REG_FG, 4'h0}
	};

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd        = '0;
	logic [CHAR_W-1:0]    char_code  = '0;
	logic [IDX_W-1:0]     cell_index = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [CELL_W-1:0]    read_data;
	logic [POS_W-1:0]     cursor_pos;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [COLOR_W-1:0]   cfg_data   = '0;

	// shadow of the terminal
	logic [CELL_W-1:0]  screen_shadow [CELLS];
	int                 cursor_shadow;
	logic [COLOR_W-1:0] fg_shadow;
	logic [COLOR_W-1:0] bg_shadow;

	cell_word_t pending_words [$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int holds_asked    = 0;
	int holds_taken    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int mismatches     = 0;
	int colour_writes  = 0;
	int op_count [4]   = '{0, 0, 0, 0};
	int newline_count  = 0;
	int scroll_count   = 0;
	int outside_reads  = 0;

	text_terminal_writer_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.cursor_pos (cursor_pos),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic void terminal_step(
		input  cmd_t              op,
		input  logic [CHAR_W-1:0] ch,
		input  logic [IDX_W-1:0]  ix,
		output cell_word_t        res
	);
		int i;
		res.data = '0;
		op_count[op]++;
		case (op)
			CMD_PUT: begin
				if (cursor_shadow >= CELLS) begin
					for (i = 0; i < CELLS - COLUMNS; i++)
						screen_shadow[i] = screen_shadow[i + COLUMNS];
					for (i = CELLS - COLUMNS; i < CELLS; i++)
						screen_shadow[i] = {bg_shadow, fg_shadow, 8'h00};
					cursor_shadow = cursor_shadow - COLUMNS;
					scroll_count++;
				end
				if (ch == NEWLINE_CODE) begin
					cursor_shadow = cursor_shadow + COLUMNS - (cursor_shadow % COLUMNS);
					newline_count++;
				end else begin
					if (cursor_shadow < CELLS)
						screen_shadow[cursor_shadow] = {bg_shadow, fg_shadow, ch};
					cursor_shadow++;
				end
				if (cursor_shadow > CELLS)
					cursor_shadow = CELLS;
			end
			CMD_FILL: begin
				for (i = 0; i < CELLS; i++)
					screen_shadow[i] = {bg_shadow, fg_shadow, ch};
			end
			CMD_READ: begin
				if (ix < CELLS)
					res.data = screen_shadow[ix];
				else
					outside_reads++;
			end
			default: ;
		endcase
		res.pos = cursor_shadow[POS_W-1:0];
	endfunction

	task automatic send_word(
		input cmd_t              op,
		input logic [CHAR_W-1:0] ch,
		input logic [IDX_W-1:0]  ix,
		input logic              typed,
		input cell_word_t        typed_res
	);
		cell_word_t res;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		char_code  <= ch;
		cell_index <= ix;
		do @(posedge clk); while (!(in_valid && in_ready));
		terminal_step(op, ch, ix, res);
		pending_words.push_back(typed ? typed_res : res);
	endtask

	task automatic send_random_word();
		cmd_t              op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  ix;
		int                r;
		r  = $urandom_range(99);
		ch = CHAR_W'($urandom_range(255));
		ix = IDX_W'($urandom_range(2047));
		if (r < 78) begin
			op = CMD_PUT;
			if ($urandom_range(99) < 12)
				ch = NEWLINE_CODE;
		end else if (r < 94) begin
			op = CMD_READ;
			case ($urandom_range(3))
				0: ix = IDX_W'($urandom_range(CELLS - 1));
				1: ix = IDX_W'((cursor_shadow > 0) ? cursor_shadow - 1 : 0);
				2: ix = IDX_W'(CELLS - COLUMNS + $urandom_range(COLUMNS - 1));
				default: ;
			endcase
		end else if (r < 97) begin
			op = CMD_NONE;
		end else begin
			op = CMD_FILL;
		end
		send_word(op, ch, ix, 1'b0, '0);
	endtask

	task automatic wait_all_delivered();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_colour(input logic [CFG_IDX_W-1:0] sel, input logic [COLOR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (sel == REG_FG)
			fg_shadow = val;
		else if (sel == REG_BG)
			bg_shadow = val;
		colour_writes++;
	endtask

	// result side: random stalls plus the occasional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (holds_taken != holds_asked) begin
			holds_taken++;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		cell_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: read_data %h cursor_pos %0d",
					$time, read_data, cursor_pos);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (read_data !== want.data) begin
					$display("%0t read_data mismatch: expected %h, got %h",
						$time, want.data, read_data);
					mismatches++;
				end
				if (cursor_pos !== want.pos) begin
					$display("%0t cursor_pos mismatch: expected %0d, got %0d",
						$time, want.pos, cursor_pos);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int k;
		int n;
		int p;
		logic [COLOR_W-1:0] fg_pick [4];
		logic [COLOR_W-1:0] bg_pick [4];
		fg_pick = '{4'h0, 4'h0, 4'hF, 4'hF};
		bg_pick = '{4'h0, 4'hF, 4'h0, 4'hF};
		for (k = 0; k < CELLS; k++)
			screen_shadow[k] = RESET_CELL;
		cursor_shadow = 0;
		fg_shadow     = RESET_FG;
		bg_shadow     = RESET_BG;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NROWS; k++) begin
			if (SCRIPT[k].kind == ROW_REG) begin
				wait_all_delivered();
				write_colour(SCRIPT[k].reg_sel, SCRIPT[k].reg_val);
			end else begin
				for (n = 0; n < SCRIPT[k].reps; n++)
					send_word(SCRIPT[k].op, SCRIPT[k].ch, SCRIPT[k].ix, SCRIPT[k].typed,
						{SCRIPT[k].t_data, SCRIPT[k].t_pos});
			end
		end

		for (p = 0; p < PHASES; p++) begin
			wait_all_delivered();
			if (p < 4) begin
				write_colour(REG_FG, fg_pick[p]);
				write_colour(REG_BG, bg_pick[p]);
			end else begin
				write_colour(REG_FG, COLOR_W'($urandom_range(15)));
				write_colour(REG_BG, COLOR_W'($urandom_range(15)));
			end
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
				default: begin src_idle_pct = 22; sink_stall_pct = 22; end
			endcase
			// long hold on the result side while words keep coming
			if (p % 4 == 0)
				holds_asked++;
			for (n = 0; n < WORDS_PER_PHASE; n++)
				send_random_word();
		end

		wait_all_delivered();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t %0d result words never arrived", $time, pending_words.size());
			mismatches++;
		end

		$display("covered %0d put (%0d newline, %0d scroll), %0d fill,",
			op_count[CMD_PUT], newline_count, scroll_count, op_count[CMD_FILL]);
		$display("%0d read (%0d outside screen), %0d unused, colour writes %0d, mismatches %0d",
			op_count[CMD_READ], outside_reads, op_count[CMD_NONE], colour_writes,
			mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
